// ===== rtl/core/pcfc_pkg.sv =====
// shared types and constants for the parallel camera frame capture block
`timescale 1ns / 1ps

package pcfc_pkg;

  localparam int WIDTH_W = 10;
  localparam int HEIGHT_W = 9;
  localparam int ADDR_W = 19;
  localparam int DATA_W = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_INDEX_W = 1;

  localparam int MAX_WIDTH_DEF = 640;
  localparam int MAX_HEIGHT_DEF = 480;

  localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RST = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_VS_LOW1   = 3'd1,
    PH_VS_HIGH   = 3'd2,
    PH_VS_LOW2   = 3'd3,
    PH_HREF_HIGH = 3'd4,
    PH_PCLK_HIGH = 3'd5,
    PH_PCLK_LOW  = 3'd6,
    PH_HREF_LOW  = 3'd7
  } pcfc_phase_t;

  typedef struct packed {
    logic              action;
    logic              vsync_level;
    logic              href_level;
    logic              pclk_level;
    logic [DATA_W-1:0] data_bits;
  } pcfc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] pixel_value;
    logic [ADDR_W-1:0] pixel_address;
    logic              frame_end;
  } pcfc_out_t;

endpackage

// ===== rtl/core/pcfc_in_reg.sv =====
// input register holding one accepted pin sample or arm request
`timescale 1ns / 1ps

module pcfc_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  pcfc_pkg::pcfc_in_t  sample,
  input  logic                advance,
  output logic                held_valid,
  output pcfc_pkg::pcfc_in_t  held
);

  assign sample_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      held <= sample;
    end
  end

endmodule

// ===== rtl/core/pcfc_core.sv =====
// capture sequencer: sync/line/pixel clock tracking, counters and pixel build
`timescale 1ns / 1ps

module pcfc_core #(
  parameter int MAX_WIDTH = pcfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pcfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step_en,
  input  pcfc_pkg::pcfc_in_t                  item,
  input  logic [pcfc_pkg::WIDTH_W-1:0]        frame_width,
  input  logic [pcfc_pkg::HEIGHT_W-1:0]       frame_height,
  output logic                                res_valid,
  output pcfc_pkg::pcfc_out_t                 res
);

  localparam int CMP_W = 13;
  localparam logic [CMP_W-1:0] MaxW = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MaxH = CMP_W'(MAX_HEIGHT);

  pcfc_pkg::pcfc_phase_t phase, phase_next;
  logic [pcfc_pkg::WIDTH_W-1:0]  column_count, column_count_next;
  logic [pcfc_pkg::HEIGHT_W-1:0] row_count, row_count_next;
  logic [pcfc_pkg::ADDR_W-1:0]   next_address, next_address_next;

  logic [pcfc_pkg::WIDTH_W-1:0]  w;
  logic [pcfc_pkg::HEIGHT_W-1:0] h;
  logic last_col, last_row, last_pix, col_done;

  // clamp live registers to 1..max
  always_comb begin
    if (frame_width == '0) begin
      w = pcfc_pkg::WIDTH_W'(1);
    end else if ({3'b0, frame_width} > MaxW) begin
      w = MaxW[pcfc_pkg::WIDTH_W-1:0];
    end else begin
      w = frame_width;
    end
    if (frame_height == '0) begin
      h = pcfc_pkg::HEIGHT_W'(1);
    end else if ({4'b0, frame_height} > MaxH) begin
      h = MaxH[pcfc_pkg::HEIGHT_W-1:0];
    end else begin
      h = frame_height;
    end
  end

  assign last_col = ({1'b0, column_count} + 11'd1) >= {1'b0, w};
  assign last_row = ({1'b0, row_count} + 10'd1) >= {1'b0, h};
  assign last_pix = last_col && last_row;
  assign col_done = column_count >= w;

  // next phase
  always_comb begin
    phase_next = phase;
    if (step_en) begin
      if (item.action) begin
        if (phase == pcfc_pkg::PH_IDLE) begin
          phase_next = pcfc_pkg::PH_VS_LOW1;
        end
      end else begin
        unique case (phase)
          pcfc_pkg::PH_IDLE: begin
            phase_next = pcfc_pkg::PH_IDLE;
          end
          pcfc_pkg::PH_VS_LOW1: begin
            if (!item.vsync_level) phase_next = pcfc_pkg::PH_VS_HIGH;
          end
          pcfc_pkg::PH_VS_HIGH: begin
            if (item.vsync_level) phase_next = pcfc_pkg::PH_VS_LOW2;
          end
          pcfc_pkg::PH_VS_LOW2: begin
            if (!item.vsync_level) phase_next = pcfc_pkg::PH_HREF_HIGH;
          end
          pcfc_pkg::PH_HREF_HIGH: begin
            if (item.href_level) phase_next = pcfc_pkg::PH_PCLK_HIGH;
          end
          pcfc_pkg::PH_PCLK_HIGH: begin
            if (item.pclk_level) begin
              phase_next = last_pix ? pcfc_pkg::PH_IDLE : pcfc_pkg::PH_PCLK_LOW;
            end
          end
          pcfc_pkg::PH_PCLK_LOW: begin
            if (!item.pclk_level) begin
              phase_next = col_done ? pcfc_pkg::PH_HREF_LOW : pcfc_pkg::PH_PCLK_HIGH;
            end
          end
          pcfc_pkg::PH_HREF_LOW: begin
            if (!item.href_level) phase_next = pcfc_pkg::PH_HREF_HIGH;
          end
          default: begin
            phase_next = pcfc_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // counters and pixel result
  always_comb begin
    column_count_next = column_count;
    row_count_next = row_count;
    next_address_next = next_address;
    res_valid = 1'b0;
    res.pixel_value = item.data_bits;
    res.pixel_address = next_address;
    res.frame_end = last_pix;
    if (step_en) begin
      if (item.action) begin
        if (phase == pcfc_pkg::PH_IDLE) begin
          column_count_next = '0;
          row_count_next = '0;
          next_address_next = '0;
        end
      end else if (phase == pcfc_pkg::PH_PCLK_HIGH && item.pclk_level) begin
        res_valid = 1'b1;
        next_address_next = next_address + pcfc_pkg::ADDR_W'(1);
        if (last_pix) begin
          column_count_next = '0;
          row_count_next = '0;
        end else begin
          column_count_next = column_count + pcfc_pkg::WIDTH_W'(1);
        end
      end else if (phase == pcfc_pkg::PH_PCLK_LOW && !item.pclk_level && col_done) begin
        column_count_next = '0;
      end else if (phase == pcfc_pkg::PH_HREF_LOW && !item.href_level) begin
        row_count_next = row_count + pcfc_pkg::HEIGHT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pcfc_pkg::PH_IDLE;
      column_count <= '0;
      row_count <= '0;
      next_address <= '0;
    end else begin
      phase <= phase_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
      next_address <= next_address_next;
    end
  end

endmodule

// ===== rtl/core/pcfc_out_reg.sv =====
// result register between the sequencer and the pixel channel
`timescale 1ns / 1ps

module pcfc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  pcfc_pkg::pcfc_out_t  res,
  output logic                 advance,
  output logic                 pixel_valid,
  input  logic                 pixel_ready,
  output pcfc_pkg::pcfc_out_t  pixel
);

  // slot is free, or its request leaves this cycle
  assign advance = !pixel_valid || pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      pixel <= res;
    end
  end

endmodule

// ===== rtl/core/parallel_camera_frame_capture_top.sv =====
// path: a pin sample waits in the input register, its pixel request in the result register
// throughput: one sample or arm request per cycle, set by the single-step sequencer
// stalls on the pixel side hold the input register; one sample waits there meanwhile
// reset: synchronous, active high; sequencer idle, counters zero,
//   frame_width 640, frame_height 480, both registers empty
`timescale 1ns / 1ps

module parallel_camera_frame_capture_top #(
  parameter int MAX_WIDTH = pcfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pcfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [pcfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pcfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // pin sample / arm channel
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  pcfc_pkg::pcfc_in_t                   sample,
  // captured pixel channel
  output logic                                 pixel_valid,
  input  logic                                 pixel_ready,
  output pcfc_pkg::pcfc_out_t                  pixel
);

  // frame size registers, read live by the sequencer
  logic [pcfc_pkg::WIDTH_W-1:0]  frame_width;
  logic [pcfc_pkg::HEIGHT_W-1:0] frame_height;

  logic               held_valid;
  pcfc_pkg::pcfc_in_t held;
  logic               advance;
  logic               step_en;
  logic               res_valid;
  pcfc_pkg::pcfc_out_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= pcfc_pkg::FRAME_WIDTH_RST;
      frame_height <= pcfc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcfc_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[pcfc_pkg::WIDTH_W-1:0];
        end
        pcfc_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[pcfc_pkg::HEIGHT_W-1:0];
        end
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  // stage 1: accepted request waits here
  pcfc_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .advance      (advance),
    .held_valid   (held_valid),
    .held         (held)
  );

  // the held request is consumed only when the result slot can take its outcome
  assign step_en = held_valid && advance;

  // stage 2: sequencer steps once per request, builds pixel on a pclk high sample
  pcfc_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_en),
    .item         (held),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result register drives the pixel channel
  pcfc_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .advance     (advance),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

endmodule

// ===== rtl/core/pcfc_checker.sv =====
// port-level checker for the frame capture block, bound to the top level
`timescale 1ns / 1ps

module pcfc_port_checks (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_ready,
  input logic                pixel_valid,
  input logic                pixel_ready,
  input pcfc_pkg::pcfc_out_t pixel
);

  logic                          have_prev;
  logic                          end_seen;
  logic [pcfc_pkg::ADDR_W-1:0]   prev_addr;
  logic                          pix_acc;

  assign pix_acc = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      end_seen <= 1'b0;
    end else if (pix_acc) begin
      have_prev <= 1'b1;
      end_seen <= pixel.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      prev_addr <= pixel.pixel_address;
    end
  end

  // stalled pixel request holds
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("pixel request changed while stalled");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !pixel_valid)
    else $error("pixel request right after reset");

  // a new frame starts at address zero
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && end_seen |-> pixel.pixel_address == '0)
    else $error("frame did not start at address zero");

  // pixels within a frame carry consecutive addresses
  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && have_prev && !end_seen |->
      pixel.pixel_address == prev_addr + pcfc_pkg::ADDR_W'(1))
    else $error("pixel address skipped");

  // input side is never blocked while the output side is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid && !$past(rst) && !$past(sample_valid) |-> sample_ready)
    else $error("sample channel blocked with empty pipeline");

endmodule

bind parallel_camera_frame_capture_top pcfc_port_checks u_pcfc_port_checks (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .pixel        (pixel)
);

// ===== bench/pcfc_checker.sv =====
// watches the capture block's channels, predicts each pixel request and compares
`timescale 1ns / 1ps

module pcfc_checker
  import pcfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  pcfc_in_t               sample,
  input  logic                   pixel_valid,
  input  logic                   pixel_ready,
  input  pcfc_out_t              pixel,
  output int                     errors,
  output int                     pending
);

  pcfc_phase_t          phase;
  logic [WIDTH_W-1:0]   width_reg;
  logic [HEIGHT_W-1:0]  height_reg;
  logic [WIDTH_W-1:0]   col;
  logic [HEIGHT_W-1:0]  row;
  logic [ADDR_W-1:0]    addr;
  pcfc_out_t            expected_pixels[$];
  int                   mismatches = 0;

  function automatic int limit_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one pin sample or arm request through the capture sequencer
  function automatic void capture_step(pcfc_in_t s);
    int        w;
    int        h;
    pcfc_out_t px;
    w = limit_dim(int'(width_reg), MAX_WIDTH_DEF);
    h = limit_dim(int'(height_reg), MAX_HEIGHT_DEF);
    if (s.action) begin
      if (phase == PH_IDLE) begin
        phase = PH_VS_LOW1;
        col = '0;
        row = '0;
        addr = '0;
      end
      return;
    end
    case (phase)
      PH_VS_LOW1: if (!s.vsync_level) phase = PH_VS_HIGH;
      PH_VS_HIGH: if (s.vsync_level) phase = PH_VS_LOW2;
      PH_VS_LOW2: if (!s.vsync_level) phase = PH_HREF_HIGH;
      PH_HREF_HIGH: if (s.href_level) phase = PH_PCLK_HIGH;
      PH_PCLK_HIGH: if (s.pclk_level) begin
        px.pixel_value = s.data_bits;
        px.pixel_address = addr;
        px.frame_end = (int'(col) + 1 >= w) && (int'(row) + 1 >= h);
        expected_pixels.push_back(px);
        addr = addr + ADDR_W'(1);
        if (px.frame_end) begin
          phase = PH_IDLE;
          col = '0;
          row = '0;
        end else begin
          col = col + WIDTH_W'(1);
          phase = PH_PCLK_LOW;
        end
      end
      PH_PCLK_LOW: if (!s.pclk_level) begin
        if (int'(col) >= w) begin
          col = '0;
          phase = PH_HREF_LOW;
        end else begin
          phase = PH_PCLK_HIGH;
        end
      end
      PH_HREF_LOW: if (!s.href_level) begin
        row = row + HEIGHT_W'(1);
        phase = PH_HREF_HIGH;
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    pcfc_out_t want;
    if (rst) begin
      phase = PH_IDLE;
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col = '0;
      row = '0;
      addr = '0;
      expected_pixels.delete();
    end else begin
      if (pixel_valid && pixel_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none, got value %0d address %0d end %b",
                   $time, pixel.pixel_value, pixel.pixel_address, pixel.frame_end);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_value", want.pixel_value, pixel.pixel_value);
          compare_field("pixel_address", want.pixel_address, pixel.pixel_address);
          compare_field("frame_end", want.frame_end, pixel.frame_end);
        end
      end
      if (sample_valid && sample_ready) capture_step(sample);
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data[WIDTH_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
    errors <= mismatches;
    pending <= expected_pixels.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// stimulus and verdict for the parallel camera frame capture block
`timescale 1ns / 1ps

module tb_top;
  import pcfc_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE = 6;
  localparam int HOLD_CYCLES = 200; // long receiver hold-off so the input side backs up

  typedef enum {PIN_VSYNC, PIN_HREF, PIN_PCLK} pin_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   sample_valid;
  logic                   sample_ready;
  pcfc_in_t               sample;
  logic                   pixel_valid;
  logic                   pixel_ready;
  pcfc_out_t              pixel;

  int mismatch_count;
  int pending_pixels;

  // shared between the two sides: calm turns off all idling for a phase,
  // hold_requests asks the receiver for one long hold-off
  bit calm = 1'b0;
  int hold_requests = 0;
  int frame_items = 0;

  parallel_camera_frame_capture_top dut (.*);

  pcfc_checker capture_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .errors       (mismatch_count),
    .pending      (pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycles of idling before the next request; at least half of the draws are zero
  function automatic int pause_len();
    if (calm) return 0;
    if ($urandom_range(0, 1) == 1) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic pcfc_in_t random_pins();
    pcfc_in_t s;
    s.action = 1'b0;
    s.vsync_level = 1'($urandom_range(0, 1));
    s.href_level = 1'($urandom_range(0, 1));
    s.pclk_level = 1'($urandom_range(0, 1));
    s.data_bits = 8'($urandom_range(0, 255));
    return s;
  endfunction

  // offer one request and hold it until the block takes it; valid stays high
  // on return so back-to-back requests need no drop
  task automatic send(input pcfc_in_t s);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic arm();
    pcfc_in_t s;
    s = random_pins();
    s.action = 1'b1;
    send(s);
  endtask

  // feed samples until one satisfies the wait on the chosen pin; the misses
  // in front of it carry the opposite level, or now and then a stray arm
  task automatic wait_for(input pin_t pin, input logic level, input int noise_pct,
                          input int data = -1);
    pcfc_in_t s;
    int       extra;
    logic     lvl;
    extra = ($urandom_range(0, 99) < noise_pct) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i <= extra; i++) begin
      s = random_pins();
      lvl = (i == extra) ? level : ~level;
      if (i < extra && $urandom_range(0, 15) == 0) begin
        s.action = 1'b1; // arm while busy is dropped
      end else begin
        case (pin)
          PIN_VSYNC: s.vsync_level = lvl;
          PIN_HREF: s.href_level = lvl;
          default: s.pclk_level = lvl;
        endcase
      end
      if (i == extra && data >= 0) s.data_bits = 8'(data);
      send(s);
      frame_items++;
    end
  endtask

  // a well-formed frame; the block goes idle on the last pixel so the
  // trailing pclk low and href low are not sent
  task automatic capture_frame(input int w, input int h, input int noise_pct);
    arm();
    wait_for(PIN_VSYNC, 1'b0, noise_pct);
    wait_for(PIN_VSYNC, 1'b1, noise_pct);
    wait_for(PIN_VSYNC, 1'b0, noise_pct);
    for (int r = 0; r < h; r++) begin
      wait_for(PIN_HREF, 1'b1, noise_pct);
      for (int c = 0; c < w; c++) begin
        wait_for(PIN_PCLK, 1'b1, noise_pct);
        if (r == h - 1 && c == w - 1) return;
        wait_for(PIN_PCLK, 1'b0, noise_pct);
      end
      wait_for(PIN_HREF, 1'b0, noise_pct);
    end
  endtask

  // drop valid and wait until every predicted pixel request has come out
  task automatic drain();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write both size registers on back-to-back edges
  task automatic set_dims(input int wv, input int hv);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(wv);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(hv);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // effective size after masking to the register width and clamping
  function automatic int eff_dim(int v, int mask, int hi);
    v = v & mask;
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // receiver: random stall per pixel request, plus the long hold-off on demand
  initial begin : receiver
    int stall;
    int hold_served;
    hold_served = 0;
    pixel_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != hold_served) begin
        hold_served++;
        pixel_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pause_len();
        if (stall > 0) begin
          pixel_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      pixel_ready <= 1'b1;
      do @(posedge clk); while (!pixel_valid);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int       w_val;
    int       h_val;
    int       phase_no;
    pcfc_in_t s;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    sample_valid <= 1'b0;
    sample <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pin samples while idle are dropped: all pins high, then all low
    s = '{action: 1'b0, vsync_level: 1'b1, href_level: 1'b1, pclk_level: 1'b1,
          data_bits: 8'hFF};
    send(s);
    s = '0;
    send(s);

    // reset size 640x480; second arm lands while busy and is dropped
    arm();
    arm();
    wait_for(PIN_VSYNC, 1'b0, 0);
    wait_for(PIN_VSYNC, 1'b1, 0);
    wait_for(PIN_VSYNC, 1'b0, 0);
    wait_for(PIN_HREF, 1'b1, 0);
    wait_for(PIN_PCLK, 1'b1, 0, 8'hFF);
    wait_for(PIN_PCLK, 1'b0, 0);
    wait_for(PIN_PCLK, 1'b1, 0, 8'h00);
    wait_for(PIN_PCLK, 1'b0, 0);

    // shrink to 1x1 mid-frame: the column count is already past the limit,
    // so the next pixel closes the frame
    drain();
    set_dims(1, 1);
    wait_for(PIN_PCLK, 1'b1, 0, 8'h55);

    // zero sizes clamp up to one pixel
    drain();
    set_dims(0, 0);
    arm();
    wait_for(PIN_VSYNC, 1'b0, 0);
    wait_for(PIN_VSYNC, 1'b1, 0);
    wait_for(PIN_VSYNC, 1'b0, 0);
    wait_for(PIN_HREF, 1'b1, 0);
    wait_for(PIN_PCLK, 1'b1, 0, 8'hAA);

    // 2x2 exercises the end of line and the row step
    drain();
    set_dims(2, 2);
    capture_frame(2, 2, 0);

    // random phases: new sizes, then a few frames, broken frames or idle noise
    frame_items = 0;
    phase_no = 0;
    while (frame_items < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 7) == 0) begin
        w_val = $urandom_range(9, 40);
        h_val = $urandom_range(0, 2);
      end else begin
        w_val = $urandom_range(0, 8);
        h_val = $urandom_range(0, 5);
      end
      if ($urandom_range(0, 15) == 0) h_val = h_val | 512; // masked away by the register
      set_dims(w_val, h_val);
      calm = ($urandom_range(0, 3) == 0);
      if (phase_no % 8 == 0) begin
        // long receiver hold-off while the sender keeps offering requests
        calm = 1'b1;
        hold_requests++;
      end
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: begin
            // broken frame: arm then unstructured pin samples
            arm();
            repeat ($urandom_range(5, 40)) begin
              send(random_pins());
              frame_items++;
            end
          end
          1: repeat ($urandom_range(1, 6)) send(random_pins());
          default: capture_frame(eff_dim(w_val, 1023, MAX_WIDTH_DEF),
                                 eff_dim(h_val, 511, MAX_HEIGHT_DEF),
                                 $urandom_range(0, 40));
        endcase
      end
      phase_no++;
    end

    // the largest width: an oversized register clamps to a full-width line
    calm = 1'b0;
    drain();
    set_dims(1023, 1);
    capture_frame(MAX_WIDTH_DEF, 1, 5);
    drain();

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
